/* design/sadf_pkg.sv */
// sadf_pkg: shared constants, types and the crc-32 function for the
// sliding acknowledge frame detector. No dependencies.

package sadf_pkg;

  localparam int WinLen  = 16;
  localparam int KeepLen = 15;
  localparam int CrcLen  = 12;
  localparam int CntW    = $clog2(WinLen);
  localparam int QDepth  = 2;
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [31:0] AckMagic  = 32'h3141_424C;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] StatusOk  = 32'h0000_0001;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef logic [KeepLen-1:0][7:0] win_t;
  typedef logic [WinLen-1:0][7:0]  frame_t;

  // reflected crc-32, preset all ones, inverted result
  function automatic logic [31:0] crc_head(input logic [CrcLen-1:0][7:0] b);
    logic [31:0] c;
    c = '1;
    for (int i = 0; i < CrcLen; i++) begin
      c = c ^ {24'd0, b[i]};
      for (int k = 0; k < 8; k++) begin
        c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
      end
    end
    return ~c;
  endfunction

endpackage

/* design/sadf_in_if.sv */
// sadf_in_if: input channel of the frame detector (valid, ready, item).
// Depends on nothing.

interface sadf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

/* design/sadf_out_if.sv */
// sadf_out_if: result channel of the frame detector (valid, ready, item).
// Depends on nothing.

interface sadf_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic resend;

  modport source (output valid, output matched, output resend, input ready);
  modport sink   (input valid, input matched, input resend, output ready);
endinterface

/* design/sadf_front.sv */
// sadf_front: accepts input items, classifies them into commands and holds
// them in a two-entry queue. Depends on sadf_pkg and sadf_in_if.

module sadf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sadf_in_if.sink       in_i,
  output logic          cmd_valid_o,
  output sadf_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);

  sadf_pkg::cmd_t                     q_mem_q [sadf_pkg::QDepth];
  logic                               wr_ptr_q, wr_ptr_d;
  logic                               rd_ptr_q, rd_ptr_d;
  logic [sadf_pkg::QCntW-1:0]         cnt_q, cnt_d;
  logic                               push, pop;
  sadf_pkg::cmd_t                     new_cmd;

  assign in_i.ready  = (cnt_q != sadf_pkg::QCntW'(sadf_pkg::QDepth));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // classify
  always_comb begin
    new_cmd.op   = in_i.kind ? sadf_pkg::OP_FLUSH : sadf_pkg::OP_BYTE;
    new_cmd.data = in_i.rx_byte;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= new_cmd;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sadf_pkg::QCntW'(sadf_pkg::QDepth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == sadf_pkg::QCntW'(sadf_pkg::QDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

/* design/sadf_back.sv */
// sadf_back: runs queued commands against the 15-byte window, checks the
// frame and crc, and registers the result. Depends on sadf_pkg, sadf_out_if.

module sadf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           cmd_valid_i,
  input  sadf_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  sadf_out_if.source     out_o
);

  sadf_pkg::win_t              win_q, win_d;
  logic [sadf_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]                 exp_q;
  logic                        out_valid_q, out_valid_d;
  logic                        matched_q, matched_d;
  logic                        resend_q, resend_d;
  sadf_pkg::frame_t            frame;
  logic                        full;
  logic                        hit;
  logic                        pop;

  assign frame = {cmd_i.data, win_q};
  assign full  = (cnt_q == sadf_pkg::CntW'(sadf_pkg::KeepLen));
  assign hit   = (frame[3:0] == sadf_pkg::AckMagic)
              && (frame[7:4] == exp_q)
              && (frame[11:8] == sadf_pkg::StatusOk)
              && (frame[15:12] == sadf_pkg::crc_head(frame[11:0]));

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = matched_q;
  assign out_o.resend  = resend_q;

  always_comb begin
    win_d       = win_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    matched_d   = matched_q;
    resend_d    = resend_q;
    if (pop) begin
      out_valid_d = 1'b1;
      matched_d   = 1'b0;
      resend_d    = 1'b0;
      unique case (cmd_i.op)
        sadf_pkg::OP_FLUSH: begin
          cnt_d    = '0;
          resend_d = 1'b1;
        end
        sadf_pkg::OP_BYTE: begin
          if (full) begin
            if (hit) begin
              cnt_d     = '0;
              matched_d = 1'b1;
            end else begin
              win_d = frame[sadf_pkg::WinLen-1:1];
            end
          end else begin
            for (int i = 0; i < sadf_pkg::KeepLen; i++) begin
              if (cnt_q == sadf_pkg::CntW'(i)) begin
                win_d[i] = cmd_i.data;
              end
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      exp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q     <= win_d;
    matched_q <= matched_d;
    resend_q  <= resend_d;
  end

  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.op == sadf_pkg::OP_BYTE && full && hit) |=> (cnt_q == '0))
    else $error("window not cleared after frame match");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_q)
    else $error("no result after command");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(matched_q && resend_q))
    else $error("matched and resend both set");

  a_miss_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.op == sadf_pkg::OP_BYTE && full && !hit)
      |=> (cnt_q == sadf_pkg::CntW'(sadf_pkg::KeepLen)))
    else $error("window count lost after miss");

endmodule

/* design/sliding_ack_frame_detector_unit.sv */
// sliding_ack_frame_detector_unit: top level, front queue plus back checker.
// Depends on sadf_pkg, sadf_in_if, sadf_out_if, sadf_front, sadf_back.
//
//   channel   dir  handshake     payload
//   in_i      in   valid/ready   kind, rx_byte
//   out_o     out  valid/ready   matched, resend
//   cfg       in   cfg_we_i      cfg_wdata_i (expected_value)
//
// one item per cycle sustained while out_o is ready; a taken item waits first in
// the queue, then its result is held in the output register
// the frame check and crc over the window head finish in the back stage cycle
// reset clears the window count, the queue and expected_value; no sweep
// an output stall fills the two-entry queue, then in_i.ready drops

module sliding_ack_frame_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sadf_in_if.sink     in_i,
  sadf_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic           cmd_valid;
  logic           cmd_ready;
  sadf_pkg::cmd_t cmd;

  sadf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  sadf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

/* tb/tb_sliding_ack_frame_detector_unit.sv */
// tb_sliding_ack_frame_detector_unit: self-checking bench for the acknowledge frame
// detector; a scoreboard class predicts matched/resend per item and checks results.
// Depends on sadf_pkg, sadf_in_if, sadf_out_if and sliding_ack_frame_detector_unit.

module tb_sliding_ack_frame_detector_unit;
  import sadf_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned PhaseItems  = 210;
  localparam int unsigned PressureAt  = 300;
  localparam int unsigned PressureLen = 200;

  typedef struct packed {
    logic matched;
    logic resend;
  } ack_verdict_t;

  typedef enum int {
    FRAME_OK,
    FRAME_BAD_VALUE,
    FRAME_BAD_STATUS,
    FRAME_BAD_CRC,
    FRAME_BAD_MAGIC,
    FRAME_CUT
  } frame_flaw_e;

  class ack_scoreboard;
    logic [7:0]   win [WinLen];
    int unsigned  fill_cnt;
    logic [31:0]  expected_value;
    ack_verdict_t due_q [$];
    int unsigned  errors;
    int unsigned  seen;

    function new();
      clear_window();
      expected_value = '0;
      errors = 0;
      seen = 0;
    endfunction

    static function logic [31:0] crc32_of(logic [CrcLen*8-1:0] head);
      logic [31:0] c;
      logic        fb;
      c = '1;
      for (int j = 0; j < CrcLen * 8; j++) begin
        fb = c[0] ^ head[j];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CrcPoly;
        end
      end
      return ~c;
    endfunction

    function void clear_window();
      foreach (win[i]) win[i] = 8'h00;
      fill_cnt = 0;
    endfunction

    function logic [31:0] le_word(int k);
      return {win[4*k+3], win[4*k+2], win[4*k+1], win[4*k]};
    endfunction

    function void set_expected(logic [31:0] v);
      expected_value = v;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_input(op_e kind, logic [7:0] rx_byte);
      ack_verdict_t        v;
      logic [CrcLen*8-1:0] head;
      logic                hit;
      v = '0;
      if (kind == OP_FLUSH) begin
        clear_window();
        v.resend = 1'b1;
        due_q.push_back(v);
        return;
      end
      if (fill_cnt >= WinLen) begin
        fill_cnt = KeepLen;
      end
      win[fill_cnt % WinLen] = rx_byte;
      fill_cnt++;
      if (fill_cnt < WinLen) begin
        due_q.push_back(v);
        return;
      end
      for (int i = 0; i < CrcLen; i++) head[8*i +: 8] = win[i];
      hit = (le_word(0) == AckMagic) && (le_word(1) == expected_value) &&
            (le_word(2) == StatusOk) && (le_word(3) == crc32_of(head));
      if (hit) begin
        clear_window();
        v.matched = 1'b1;
      end else begin
        for (int i = 0; i < KeepLen; i++) win[i] = win[i+1];
        win[KeepLen] = 8'h00;
        fill_cnt = KeepLen;
      end
      due_q.push_back(v);
    endfunction

    function void check_result(logic matched, logic resend);
      ack_verdict_t v;
      seen++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: matched=%0b resend=%0b", matched, resend);
        end
        return;
      end
      v = due_q.pop_front();
      if (v.matched !== matched || v.resend !== resend) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch: matched exp %0b got %0b, resend exp %0b got %0b",
                   seen, v.matched, matched, v.resend, resend);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  bit          quiet;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;

  ack_scoreboard sb = new();

  sadf_in_if  in_if ();
  sadf_out_if out_if ();

  sliding_ack_frame_detector_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] flip_mask();
    return (32'h1 << $urandom_range(0, 31)) | $urandom;
  endfunction

  task automatic push_item(op_e kind, logic [7:0] rx_byte);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.rx_byte <= rx_byte;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(kind, rx_byte);
    items_sent++;
  endtask

  task automatic push_junk(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_item(OP_BYTE, 8'($urandom));
  endtask

  task automatic send_frame(frame_flaw_e flaw);
    logic [31:0]         w [4];
    logic [7:0]          fb [WinLen];
    logic [CrcLen*8-1:0] head;
    int unsigned         cut_at;
    w[0] = AckMagic;
    w[1] = sb.expected_value;
    w[2] = StatusOk;
    if (flaw == FRAME_BAD_VALUE) w[1] = w[1] ^ flip_mask();
    if (flaw == FRAME_BAD_STATUS) w[2] = w[2] ^ flip_mask();
    if (flaw == FRAME_BAD_MAGIC) w[0] = w[0] ^ (32'hFF << (8 * $urandom_range(0, 3)));
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 4; k++) head[32*i + 8*k +: 8] = w[i][8*k +: 8];
    end
    w[3] = ack_scoreboard::crc32_of(head);
    if (flaw == FRAME_BAD_CRC) w[3] = w[3] ^ flip_mask();
    for (int i = 0; i < WinLen; i++) fb[i] = w[i/4][8*(i%4) +: 8];
    cut_at = (flaw == FRAME_CUT) ? $urandom_range(1, WinLen - 1) : WinLen;
    for (int unsigned i = 0; i < WinLen; i++) begin
      if (i == cut_at) begin
        push_item(OP_FLUSH, 8'($urandom));
      end
      push_item(OP_BYTE, fb[i]);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_expected(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_expected(v);
  endtask

  task automatic random_phase();
    int unsigned start;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < PhaseItems) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_junk(($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3));
        if ($urandom_range(0, 99) < 60) begin
          send_frame(FRAME_OK);
        end else begin
          send_frame(frame_flaw_e'($urandom_range(1, 5)));
        end
      end else if (r < 85) begin
        push_item(OP_BYTE, 8'($urandom));
      end else if (r < 92) begin
        push_item(OP_FLUSH, 8'($urandom));
      end else begin
        push_junk($urandom_range(0, 20));
      end
    end
  endtask

  // result side: random stalls plus one long hold-off to back up the block
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.matched, out_if.resend);
      end
      if (!hold_done && sb.seen >= PressureAt) begin
        hold_done = 1'b1;
        hold_left = PressureLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic [31:0] settings [8];
    settings = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0001,
                 $urandom, AckMagic, $urandom, 32'h8000_0000};
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.kind    = OP_BYTE;
    in_if.rx_byte = 8'h00;
    quiet         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-window timeout, byte extremes, a clean frame, timeouts
    push_item(OP_FLUSH, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h00);
    send_frame(FRAME_OK);
    push_item(OP_FLUSH, 8'hFF);
    push_item(OP_BYTE, 8'h4C);
    push_item(OP_BYTE, 8'h42);
    push_item(OP_FLUSH, 8'hA5);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_expected(settings[p]);
      quiet = (p == 2 || p == 5);
      random_phase();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/sadf_pkg.sv
design/sadf_in_if.sv
design/sadf_out_if.sv
design/sadf_front.sv
design/sadf_back.sv
design/sliding_ack_frame_detector_unit.sv
tb/tb_sliding_ack_frame_detector_unit.sv
